@@ design/ctc_pkg.sv @@
`timescale 1ns / 1ps

package ctc_pkg;

  // Arithmetic set-up of the angle engine.
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int STEP_W          = $clog2(CORDIC_STEPS);

  // Data path widths: CORDIC x/y, angle in Q16 degrees, multiplier operand and product.
  localparam int DW = 52;
  localparam int ZW = 27;
  localparam int MW = 34;
  localparam int PW = 2 * MW;

  localparam int OUT_SHIFT     = 16 - ANGLE_FRAC_BITS;
  localparam int ANGLE_LIM_RAW = 180 << ANGLE_FRAC_BITS;
  localparam int ANGLE_LIM     = (ANGLE_LIM_RAW > 32767) ? 32767 : ANGLE_LIM_RAW;
  localparam int FULL_TURN     = 360 << ANGLE_FRAC_BITS;

  localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] DEG360 = ZW'(360 * 65536);

  localparam logic signed [MW-1:0] GAIN_Q16 = MW'(39797);
  localparam logic signed [DW-1:0] GAIN_Q30 = DW'(652032874);

  localparam logic [15:0] BLEND_RESET  = 16'd29789;
  localparam logic [15:0] PERIOD_RESET = 16'd655;
  localparam logic [16:0] K_ONE        = 17'd32768;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_BLEND  = 1'b0,
    CFG_PERIOD = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic signed [15:0] rate_roll;
    logic signed [15:0] rate_pitch;
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
    logic signed [15:0] field_z;
    logic               field_present;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] roll_deg;
    logic signed [15:0] pitch_deg;
    logic        [15:0] heading_deg;
    logic               heading_valid;
  } result_t;

  // Request to and response from the shared CORDIC engine.
  typedef struct packed {
    logic                 start;
    logic                 rotate;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_rsp_t;

  // Arctangent of 2^-i in Q16 degrees.
  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = ZW'(2949120);
      5'd1:    v = ZW'(1740967);
      5'd2:    v = ZW'(919879);
      5'd3:    v = ZW'(466945);
      5'd4:    v = ZW'(234379);
      5'd5:    v = ZW'(117304);
      5'd6:    v = ZW'(58666);
      5'd7:    v = ZW'(29335);
      5'd8:    v = ZW'(14668);
      5'd9:    v = ZW'(7334);
      5'd10:   v = ZW'(3667);
      5'd11:   v = ZW'(1833);
      5'd12:   v = ZW'(917);
      5'd13:   v = ZW'(458);
      5'd14:   v = ZW'(229);
      5'd15:   v = ZW'(115);
      5'd16:   v = ZW'(57);
      5'd17:   v = ZW'(29);
      5'd18:   v = ZW'(14);
      5'd19:   v = ZW'(7);
      5'd20:   v = ZW'(4);
      5'd21:   v = ZW'(2);
      5'd22:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Sign extension of a raw sensor value to the CORDIC width.
  function automatic logic signed [DW-1:0] sx16(input logic signed [15:0] v);
    return DW'(v);
  endfunction

endpackage

@@ design/complementary_tilt_compass.sv @@
`timescale 1ns / 1ps

// Tilt-compensated compass with a complementary filter. One word is taken at a time:
// the accelerometer roll and pitch come from two vectoring passes of a shared
// 16-step CORDIC engine, are blended with the previous angles plus gyro rate times
// sample period through one shared 34 x 34 multiplier, and, when a magnetometer word
// is present, two rotation passes and one more vectoring pass give the heading.
// The input stays stalled until the word in hand has moved to the output register.
// The result sits in an output register, so the next word may be taken while it
// waits. The blend coefficient and sample period may be written at any time the
// block is idle; the port never holds off a write.

module complementary_tilt_compass (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  ctc_pkg::sample_t    sample,
  output logic                result_valid,
  input  logic                result_stall,
  output ctc_pkg::result_t    result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ctc_pkg::cfg_index_t cfg_index,
  input  logic [15:0]         cfg_data
);
  import ctc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_RV, S_RW, S_HZ, S_PW,
    S_BT, S_BG, S_BK1, S_BK2, S_BR,
    S_RR, S_RRW, S_RP, S_RPW,
    S_SS, S_SC, S_XC, S_XS, S_Y1, S_Y2, S_Y3, S_Y4,
    S_HV, S_HW, S_OUT
  } state_t;

  localparam logic signed [PW-1:0] BL_RND  = PW'(16384);
  localparam logic signed [PW-1:0] OUT_RND = PW'(2 ** (OUT_SHIFT - 1));
  localparam logic signed [PW-1:0] LIM_P   = PW'(ANGLE_LIM);
  localparam logic signed [ZW-1:0] H_RND   = ZW'(2 ** (OUT_SHIFT - 1));
  localparam logic signed [ZW-1:0] H_FULL  = ZW'(FULL_TURN);
  localparam logic signed [ZW-1:0] H_MAX   = ZW'(65535);

  state_t               state;
  sample_t              smp;
  logic [15:0]          blend_coef, sample_period;
  logic signed [15:0]   last_roll, last_pitch;
  logic [15:0]          heading;
  logic                 axis;
  logic signed [ZW-1:0] roll_grav, pitch_grav;
  logic signed [MW-1:0] g, cr, sr, cp, sp, q_ss, q_sc;
  logic signed [DW-1:0] xh, yh;
  logic signed [PW-1:0] prod, acc;

  logic signed [MW-1:0] mul_a, mul_b;
  logic [16:0]          k;
  cordic_req_t          creq;
  cordic_rsp_t          crsp;
  logic signed [DW-1:0] horiz;
  logic signed [15:0]   prev_sel, rate_sel;
  logic signed [ZW-1:0] acc_sel;
  logic signed [PW-1:0] bl_sum, bl_r, bl_o;
  logic signed [15:0]   bl_angle;
  logic signed [ZW-1:0] h_w, h_o;
  logic                 out_take;

  ctc_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  assign sample_stall = (state != S_IDLE);
  assign cfg_ready    = 1'b1;

  // The finished word moves to the output register once that register is free.
  assign out_take = (state == S_OUT) && (!result_valid || !result_stall);

  // Blend coefficient saturates at one.
  assign k = (blend_coef > 16'd32768) ? K_ONE : {1'b0, blend_coef};

  // Blend arithmetic for the axis in hand.
  always_comb begin
    prev_sel = axis ? last_pitch : last_roll;
    rate_sel = axis ? smp.rate_pitch : smp.rate_roll;
    acc_sel  = axis ? pitch_grav : roll_grav;
    bl_sum   = acc + prod + BL_RND;
    bl_r     = bl_sum >>> 15;
    bl_o     = (bl_r + OUT_RND) >>> OUT_SHIFT;
    if (bl_o > LIM_P) begin
      bl_angle = 16'(ANGLE_LIM);
    end else if (bl_o < -LIM_P) begin
      bl_angle = -16'(ANGLE_LIM);
    end else begin
      bl_angle = 16'(bl_o);
    end
  end

  // Heading wrap into a full turn.
  always_comb begin
    h_w = (crsp.z < 0) ? crsp.z + DEG360 : crsp.z;
    h_o = (h_w + H_RND) >>> OUT_SHIFT;
    if (h_o >= H_FULL) begin
      h_o = h_o - H_FULL;
    end
    if (h_o < 0) begin
      h_o = '0;
    end
    if (h_o > H_MAX) begin
      h_o = H_MAX;
    end
  end

  // Horizontal accelerometer length from the gain-corrected magnitude.
  assign horiz = DW'((prod + PW'(32768)) >>> 16);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_RW:    begin mul_a = MW'(crsp.x); mul_b = GAIN_Q16; end
      S_BT:    begin mul_a = MW'(rate_sel); mul_b = MW'(signed'({1'b0, sample_period})); end
      S_BK1:   begin mul_a = MW'(signed'({1'b0, k})); mul_b = g; end
      S_BK2:   begin mul_a = MW'(signed'({1'b0, K_ONE - k})); mul_b = MW'(acc_sel); end
      S_SS:    begin mul_a = sr; mul_b = sp; end
      S_SC:    begin mul_a = sr; mul_b = cp; end
      S_XC:    begin mul_a = MW'(smp.field_x); mul_b = cp; end
      S_XS:    begin mul_a = MW'(smp.field_z); mul_b = sp; end
      S_Y1:    begin mul_a = MW'(smp.field_x); mul_b = q_ss; end
      S_Y2:    begin mul_a = MW'(smp.field_y); mul_b = cr; end
      S_Y3:    begin mul_a = MW'(smp.field_z); mul_b = q_sc; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Requests to the CORDIC engine.
  always_comb begin
    creq = '0;
    case (state)
      S_RV: begin
        creq.start = 1'b1;
        creq.x     = sx16(smp.acc_z) <<< 14;
        creq.y     = sx16(smp.acc_y) <<< 14;
      end
      S_HZ: begin
        creq.start = 1'b1;
        creq.x     = horiz;
        creq.y     = -(sx16(smp.acc_x) <<< 14);
      end
      S_RR: begin
        creq.start  = 1'b1;
        creq.rotate = 1'b1;
        creq.z      = ZW'(last_roll) <<< OUT_SHIFT;
      end
      S_RP: begin
        creq.start  = 1'b1;
        creq.rotate = 1'b1;
        creq.z      = ZW'(last_pitch) <<< OUT_SHIFT;
      end
      S_HV: begin
        creq.start = 1'b1;
        creq.x     = xh;
        creq.y     = yh;
      end
      default: creq = '0;
    endcase
  end

  // Sequencer, state and registered outputs.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state         <= S_IDLE;
      result_valid  <= 1'b0;
      blend_coef    <= BLEND_RESET;
      sample_period <= PERIOD_RESET;
      last_roll     <= '0;
      last_pitch    <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BLEND:  blend_coef <= cfg_data;
          CFG_PERIOD: sample_period <= cfg_data;
          default:    ;
        endcase
      end
      if (out_take) begin
        result.roll_deg      <= last_roll;
        result.pitch_deg     <= last_pitch;
        result.heading_deg   <= heading;
        result.heading_valid <= smp.field_present;
        result_valid         <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            smp     <= sample;
            heading <= '0;
            axis    <= 1'b0;
            state   <= S_RV;
          end
        end
        S_RV: state <= S_RW;
        S_RW: begin
          if (crsp.done) begin
            roll_grav <= crsp.z;
            state     <= S_HZ;
          end
        end
        S_HZ: state <= S_PW;
        S_PW: begin
          if (crsp.done) begin
            pitch_grav <= crsp.z;
            state      <= S_BT;
          end
        end
        S_BT: state <= S_BG;
        S_BG: begin
          g     <= (MW'(prev_sel) <<< OUT_SHIFT) + MW'((prod + PW'(8)) >>> 4);
          state <= S_BK1;
        end
        S_BK1: state <= S_BK2;
        S_BK2: begin
          acc   <= prod;
          state <= S_BR;
        end
        S_BR: begin
          if (axis) begin
            last_pitch <= bl_angle;
            state      <= smp.field_present ? S_RR : S_OUT;
          end else begin
            last_roll <= bl_angle;
            axis      <= 1'b1;
            state     <= S_BT;
          end
        end
        S_RR: state <= S_RRW;
        S_RRW: begin
          if (crsp.done) begin
            cr    <= MW'(crsp.x);
            sr    <= MW'(crsp.y);
            state <= S_RP;
          end
        end
        S_RP: state <= S_RPW;
        S_RPW: begin
          if (crsp.done) begin
            cp    <= MW'(crsp.x);
            sp    <= MW'(crsp.y);
            state <= S_SS;
          end
        end
        S_SS: state <= S_SC;
        S_SC: begin
          q_ss  <= MW'(prod >>> 30);
          state <= S_XC;
        end
        S_XC: begin
          q_sc  <= MW'(prod >>> 30);
          state <= S_XS;
        end
        S_XS: begin
          acc   <= prod;
          state <= S_Y1;
        end
        S_Y1: begin
          xh    <= DW'(acc + prod);
          state <= S_Y2;
        end
        S_Y2: begin
          acc   <= prod;
          state <= S_Y3;
        end
        S_Y3: begin
          acc   <= acc + prod;
          state <= S_Y4;
        end
        S_Y4: begin
          yh    <= DW'(acc - prod);
          state <= S_HV;
        end
        S_HV: state <= S_HW;
        S_HW: begin
          if (crsp.done) begin
            heading <= 16'(h_o);
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/ctc_cordic.sv @@
`timescale 1ns / 1ps

module ctc_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  ctc_pkg::cordic_req_t req,
  output ctc_pkg::cordic_rsp_t rsp
);
  import ctc_pkg::*;

  logic signed [DW-1:0] x, y, x_sh, y_sh, x_next, y_next;
  logic signed [ZW-1:0] z, z_next, ang;
  logic [STEP_W-1:0]    step;
  logic                 busy, done, zero, neg, rot, ccw;

  // One micro-rotation per cycle; direction from the residual angle or from y.
  always_comb begin
    x_sh   = x >>> step;
    y_sh   = y >>> step;
    ang    = atan_q16(5'(step));
    ccw    = rot ? (z >= 0) : (y <= 0);
    x_next = ccw ? x - y_sh : x + y_sh;
    y_next = ccw ? y + x_sh : y - x_sh;
    z_next = ccw ? z - ang : z + ang;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        rot  <= req.rotate;
        if (req.rotate) begin
          // Fold the angle into the right half plane and flip the result.
          x    <= GAIN_Q30;
          y    <= '0;
          zero <= 1'b0;
          if (req.z > DEG90) begin
            z   <= req.z - DEG180;
            neg <= 1'b1;
          end else if (req.z < -DEG90) begin
            z   <= req.z + DEG180;
            neg <= 1'b1;
          end else begin
            z   <= req.z;
            neg <= 1'b0;
          end
        end else begin
          // Vectors in the left half plane start from plus or minus 180 degrees.
          neg  <= 1'b0;
          zero <= (req.x == 0) && (req.y == 0);
          if (req.x < 0) begin
            x <= -req.x;
            y <= -req.y;
            z <= (req.y >= 0) ? DEG180 : -DEG180;
          end else begin
            x <= req.x;
            y <= req.y;
            z <= '0;
          end
        end
      end else if (busy) begin
        x    <= x_next;
        y    <= y_next;
        z    <= z_next;
        step <= step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // A zero vector gives zero angle and zero length.
  always_comb begin
    rsp.done = done;
    rsp.x    = zero ? '0 : (neg ? -x : x);
    rsp.y    = neg ? -y : y;
    rsp.z    = zero ? '0 : z;
  end

endmodule
